// File: rtl/encoder_unwrap_rate_average_defines.svh
// Assertion macros shared by the encoder unwrap block.
// Depends on nothing; taken in by the top level with `include.
`ifndef ENCODER_UNWRAP_RATE_AVERAGE_DEFINES_SVH
`define ENCODER_UNWRAP_RATE_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EURA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define EURA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/eura_pkg.sv
// Types and constants of the encoder unwrap and rate averaging block.
// Depends on nothing; used by every module of the block.
package eura_pkg;

   localparam int READING_W = 13;
   localparam int TURN_W    = 16;
   localparam int COUNT_W   = 30;
   localparam int STEP_W    = 14;

   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

   // One turn in 15-bit signed arithmetic, wide enough to correct a step.
   localparam logic signed [STEP_W:0] COUNTS_PER_TURN = 15'sd8192;

   localparam logic [READING_W-1:0] WRAP_THRESHOLD_RESET = 13'd6500;

   typedef enum logic [0:0] {
      CSR_ANGLE_BIAS     = 1'b0,
      CSR_WRAP_THRESHOLD = 1'b1
   } csr_index_type;

   // Result of unwrapping one reading.
   typedef struct packed {
      logic signed [TURN_W-1:0] turns;
      logic signed [STEP_W-1:0] step;
   } unwrap_type;

endpackage

// File: rtl/eura_cell.sv
// One cell of the step history chain: holds one step and hands it on.
// Depends on eura_pkg.
module eura_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic signed [eura_pkg::STEP_W-1:0]  step_in,
   output logic signed [eura_pkg::STEP_W-1:0]  step_out
);

   logic signed [eura_pkg::STEP_W-1:0] step_ff;
   logic signed [eura_pkg::STEP_W-1:0] step_in_d;

   assign step_in_d = shift ? step_in : step_ff;

   // The history starts out as zeros, so the cell is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in_d;
      end
   end

   assign step_out = step_ff;

endmodule

// File: rtl/eura_unwrap.sv
// Turn-crossing detection: wrap-corrected step and saturating turn count.
// Depends on eura_pkg.
module eura_unwrap (
   input  logic [eura_pkg::READING_W-1:0]      reading,
   input  logic [eura_pkg::READING_W-1:0]      previous,
   input  logic signed [eura_pkg::TURN_W-1:0]  turns,
   input  logic [eura_pkg::READING_W-1:0]      threshold,
   output eura_pkg::unwrap_type                result
);

   logic signed [eura_pkg::STEP_W:0] diff;
   logic signed [eura_pkg::STEP_W:0] thr;
   logic signed [eura_pkg::STEP_W:0] step_wide;

   assign diff = $signed({2'b00, reading}) - $signed({2'b00, previous});
   assign thr  = $signed({2'b00, threshold});

   // A large negative jump is a forward crossing, a large positive one a
   // backward crossing; the count holds at either end of its range.
   always_comb begin
      result.turns = turns;
      step_wide    = diff;
      priority if (diff < -thr) begin
         if (turns != eura_pkg::TURN_MAX) begin
            result.turns = turns + 16'sd1;
         end
         step_wide = diff + eura_pkg::COUNTS_PER_TURN;
      end else if (diff > thr) begin
         if (turns != eura_pkg::TURN_MIN) begin
            result.turns = turns - 16'sd1;
         end
         step_wide = diff - eura_pkg::COUNTS_PER_TURN;
      end else begin
         step_wide = diff;
      end
      result.step = step_wide[eura_pkg::STEP_W-1:0];
   end

endmodule

// File: rtl/eura_mean.sv
// Running sum divided by the history depth, truncated toward zero.
// Depends on eura_pkg; division is a multiplication by a rounded-up reciprocal.
module eura_mean #(
   parameter int RATE_DEPTH = 8,
   parameter int SUM_W      = 17
) (
   input  logic signed [SUM_W-1:0]             sum,
   output logic signed [eura_pkg::STEP_W-1:0]  mean
);

   // The magnitude of the sum stays below 2**MAG_W.
   localparam int MAG_W  = SUM_W - 1;
   localparam int LOG_D  = $clog2(RATE_DEPTH);
   localparam int SHIFT  = MAG_W + LOG_D;
   localparam int RECIP  = ((1 << SHIFT) + RATE_DEPTH - 1) / RATE_DEPTH;
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W = MAG_W + RECIP_W;
   localparam int Q_W    = eura_pkg::STEP_W - 1;
   localparam logic [RECIP_W-1:0] RECIP_VEC = RECIP_W'(RECIP);

   logic                           negative;
   logic signed [SUM_W-1:0]        abs_sum;
   logic        [PROD_W-1:0]       product;
   logic        [Q_W-1:0]          quotient;
   logic signed [eura_pkg::STEP_W-1:0] q_signed;

   assign negative = sum[SUM_W-1];
   assign abs_sum  = negative ? -sum : sum;

   // With the shift at magnitude width plus log2 of the depth, the
   // rounded-up reciprocal gives the exact floor for every magnitude.
   assign product  = PROD_W'(abs_sum[MAG_W-1:0]) * PROD_W'(RECIP_VEC);
   assign quotient = product[SHIFT +: Q_W];
   assign q_signed = $signed({1'b0, quotient});
   assign mean     = negative ? -q_signed : q_signed;

endmodule

// File: rtl/encoder_unwrap_rate_average.sv
// Multi-turn encoder unwrap with step-rate moving average. Each transaction
// on the req_ channel carries one 13-bit single-turn reading (8192 counts per
// turn); each transaction on the rsp_ channel returns the saturating turn
// count, the continuous count, the angle relative to csr register 0
// (angle_bias, unit 360/8192 degree), the wrap-corrected step and the mean of
// the last RATE_DEPTH steps truncated toward zero. A step whose magnitude
// exceeds csr register 1 (wrap_threshold, reset 6500) is taken as a turn
// crossing. The block takes one transaction per clock cycle while req_stall is
// low. The loop that unwraps the reading and updates the running sum feeds the
// middle stage, followed by one stage holding the reciprocal multiplier of the
// mean that feeds the result register. The step history is a
// chain of RATE_DEPTH cells shifting once per accepted transaction, cleared
// to zero by reset, so the mean covers RATE_DEPTH steps from the start.
// Configuration may only be written while no transaction is in flight.
module encoder_unwrap_rate_average #(
   parameter int RATE_DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [eura_pkg::READING_W-1:0]        req_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eura_pkg::TURN_W-1:0]    rsp_turn_count,
   output logic signed [eura_pkg::COUNT_W-1:0]   rsp_continuous_count,
   output logic signed [eura_pkg::COUNT_W-1:0]   rsp_angle_count,
   output logic signed [eura_pkg::STEP_W-1:0]    rsp_step_rate,
   output logic signed [eura_pkg::STEP_W-1:0]    rsp_mean_rate,
   input  logic                                  csr_write,
   input  logic [0:0]                            csr_index,
   input  logic [eura_pkg::READING_W-1:0]        csr_data
);

`include "encoder_unwrap_rate_average_defines.svh"

   // The running sum of RATE_DEPTH steps of at most 8191 in magnitude.
   localparam int SUM_W = eura_pkg::STEP_W + $clog2(RATE_DEPTH);

   // Configuration registers.
   logic [eura_pkg::READING_W-1:0] angle_bias_ff;
   logic [eura_pkg::READING_W-1:0] wrap_threshold_ff;

   // State carried from one transaction to the next.
   logic [eura_pkg::READING_W-1:0]       prev_ff;
   logic signed [eura_pkg::TURN_W-1:0]   turns_ff;
   logic signed [SUM_W-1:0]              sum_ff;
   logic signed [SUM_W-1:0]              sum_in;

   // Middle stage.
   logic                                 s1_valid_ff;
   logic signed [eura_pkg::TURN_W-1:0]   s1_turns_ff;
   logic [eura_pkg::READING_W-1:0]       s1_reading_ff;
   logic signed [eura_pkg::STEP_W-1:0]   s1_step_ff;
   logic signed [SUM_W-1:0]              s1_sum_ff;

   // Result register.
   logic                                 rsp_valid_ff;
   logic signed [eura_pkg::TURN_W-1:0]   rsp_turns_ff;
   logic signed [eura_pkg::COUNT_W-1:0]  rsp_cont_ff;
   logic signed [eura_pkg::COUNT_W-1:0]  rsp_angle_ff;
   logic signed [eura_pkg::STEP_W-1:0]   rsp_step_ff;
   logic signed [eura_pkg::STEP_W-1:0]   rsp_mean_ff;

   logic                                 req_accept;
   logic                                 out_ready;
   logic                                 s1_advance;
   eura_pkg::unwrap_type                 unwrapped;
   logic signed [eura_pkg::STEP_W-1:0]   chain [RATE_DEPTH+1];
   logic signed [eura_pkg::STEP_W-1:0]   mean;
   logic signed [eura_pkg::COUNT_W-1:0]  cont;
   logic signed [eura_pkg::COUNT_W-1:0]  angle;

   // The result register frees when it is empty or being taken; the middle
   // stage moves on whenever it can hand over, so a new transaction is taken
   // even while a finished result waits on a stalled consumer, as long as the middle stage is empty.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_ready;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes; an index beyond the list cannot be formed.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_bias_ff     <= '0;
         wrap_threshold_ff <= eura_pkg::WRAP_THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_index == eura_pkg::CSR_ANGLE_BIAS) begin
            angle_bias_ff <= csr_data;
         end else begin
            wrap_threshold_ff <= csr_data;
         end
      end
   end

   eura_unwrap u_unwrap (
      .reading   (req_reading),
      .previous  (prev_ff),
      .turns     (turns_ff),
      .threshold (wrap_threshold_ff),
      .result    (unwrapped)
   );

   // Step history: the newest step enters the first cell and the oldest
   // leaves the last one, to be taken out of the running sum.
   assign chain[0] = unwrapped.step;

   for (genvar i = 0; i < RATE_DEPTH; i++) begin : g_cell
      eura_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (req_accept),
         .step_in  (chain[i]),
         .step_out (chain[i+1])
      );
   end

   assign sum_in = sum_ff - SUM_W'(chain[RATE_DEPTH]) + SUM_W'(unwrapped.step);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         turns_ff    <= '0;
         sum_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            prev_ff  <= req_reading;
            turns_ff <= unwrapped.turns;
            sum_ff   <= sum_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_turns_ff   <= unwrapped.turns;
         s1_reading_ff <= req_reading;
         s1_step_ff    <= unwrapped.step;
         s1_sum_ff     <= sum_in;
      end
   end

   // Second stage: counts from turns and reading, mean from the sum.
   assign cont  = $signed({s1_turns_ff[eura_pkg::TURN_W-1], s1_turns_ff, s1_reading_ff});
   assign angle = cont - $signed({17'd0, angle_bias_ff});

   eura_mean #(
      .RATE_DEPTH (RATE_DEPTH),
      .SUM_W      (SUM_W)
   ) u_mean (
      .sum  (s1_sum_ff),
      .mean (mean)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_turns_ff <= s1_turns_ff;
         rsp_cont_ff  <= cont;
         rsp_angle_ff <= angle;
         rsp_step_ff  <= s1_step_ff;
         rsp_mean_ff  <= mean;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_turn_count       = rsp_turns_ff;
   assign rsp_continuous_count = rsp_cont_ff;
   assign rsp_angle_count      = rsp_angle_ff;
   assign rsp_step_rate        = rsp_step_ff;
   assign rsp_mean_rate        = rsp_mean_ff;

   // An accepted transaction always occupies the middle stage next cycle.
   `EURA_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_accept, s1_valid_ff)
   // The turn count only moves when a transaction is accepted.
   `EURA_ASSERT_NEXT(a_turns_hold, clock, reset, !req_accept, $stable(turns_ff))
   // Saturation: the top of the range never wraps round to the bottom.
   `EURA_ASSERT_NEXT(a_turns_saturate, clock, reset,
      req_accept && turns_ff == eura_pkg::TURN_MAX, turns_ff != eura_pkg::TURN_MIN)
   // A corrected step never reaches the negative end of its field.
   `EURA_ASSERT_NOW(a_step_range, clock, reset, s1_valid_ff, s1_step_ff != 14'sh2000)

endmodule

// File: dv/encoder_unwrap_rate_average_tb.sv
// Self-checking testbench for the multi-turn encoder unwrap and rate average block.
// It predicts every response from its own copy of the unwrap state and ring of steps.
// It depends on eura_pkg and on the encoder_unwrap_rate_average top level only.
module encoder_unwrap_rate_average_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int READING_W     = eura_pkg::READING_W;
   localparam int TURN_W        = eura_pkg::TURN_W;
   localparam int COUNT_W       = eura_pkg::COUNT_W;
   localparam int STEP_W        = eura_pkg::STEP_W;

   // The step history depth must agree with the parameter given to the block below.
   localparam int RING_DEPTH    = 8;
   localparam int TURN_SPAN     = 8192;
   localparam int TURN_CEILING  = 32767;
   localparam int TURN_FLOOR    = -32768;
   // Drain time after the last response, a safe margin beyond the middle stage and result register.
   localparam int DRAIN_CYCLES  = 8;
   // Long receiver hold-off, so that the pipeline fills and the block stalls its input.
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 200;

   // One expected response transaction, field for field as the block presents it.
   typedef struct {
      logic signed [TURN_W-1:0]  turn_count;
      logic signed [COUNT_W-1:0] continuous_count;
      logic signed [COUNT_W-1:0] angle_count;
      logic signed [STEP_W-1:0]  step_rate;
      logic signed [STEP_W-1:0]  mean_rate;
   } encoder_sample_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   // Every input of the block starts at a known value.
   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_stall;
   logic [READING_W-1:0]        req_reading = '0;
   logic                        rsp_valid;
   logic                        rsp_stall   = 1'b0;
   logic signed [TURN_W-1:0]    rsp_turn_count;
   logic signed [COUNT_W-1:0]   rsp_continuous_count;
   logic signed [COUNT_W-1:0]   rsp_angle_count;
   logic signed [STEP_W-1:0]    rsp_step_rate;
   logic signed [STEP_W-1:0]    rsp_mean_rate;
   logic                        csr_write   = 1'b0;
   logic [0:0]                  csr_index   = eura_pkg::CSR_ANGLE_BIAS;
   logic [READING_W-1:0]        csr_data    = '0;

   // Readings waiting to be offered, and responses waiting to arrive.
   logic [READING_W-1:0] pending_readings[$];
   encoder_sample_type   expected_samples[$];

   // The predictor's own copy of the configuration and of the unwrap state.
   logic [READING_W-1:0] bias_setting = '0;
   logic [READING_W-1:0] wrap_limit   = eura_pkg::WRAP_THRESHOLD_RESET;
   logic [READING_W-1:0] last_reading = '0;
   int                   turn_total   = 0;
   int                   step_hist[RING_DEPTH];
   int                   hist_ptr     = 0;
   int                   step_total   = 0;

   // Traffic shaping: steady_flow removes all idling, random_phase arms the long hold-off.
   bit                   steady_flow  = 1'b0;
   bit                   random_phase = 1'b0;
   int                   burst_left   = 1;
   int                   gap_left     = 0;
   int unsigned          stall_cycle  = 0;
   stall_pattern_type    stall_mode   = STALL_NONE;
   int                   hold_left    = 0;
   bit                   hold_done    = 1'b0;

   int unsigned          error_count  = 0;

   encoder_unwrap_rate_average #(
      .RATE_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_reading          (req_reading),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_turn_count       (rsp_turn_count),
      .rsp_continuous_count (rsp_continuous_count),
      .rsp_angle_count      (rsp_angle_count),
      .rsp_step_rate        (rsp_step_rate),
      .rsp_mean_rate        (rsp_mean_rate),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reset is held at the start and never raised again.
   initial begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         step_hist[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // A generous ceiling on the whole run; the slowest correct run takes well under
   // two hundred thousand nanoseconds, so this only fires if the block hangs.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Works out the response to one accepted reading and advances the predicted state.
   // A jump beyond the wrap threshold is a turn crossing; the turn count saturates,
   // but the step is still corrected by a whole turn.
   function automatic encoder_sample_type predict_sample(input logic [READING_W-1:0] reading);
      encoder_sample_type s;
      int                 diff;
      int                 step;
      diff = int'(reading) - int'(last_reading);
      if (diff < -int'(wrap_limit)) begin
         if (turn_total < TURN_CEILING) begin
            turn_total++;
         end
         step = diff + TURN_SPAN;
      end else if (diff > int'(wrap_limit)) begin
         if (turn_total > TURN_FLOOR) begin
            turn_total--;
         end
         step = diff - TURN_SPAN;
      end else begin
         step = diff;
      end
      last_reading = reading;

      // Running sum over the ring; slots not yet written still hold zero.
      step_total          = step_total - step_hist[hist_ptr] + step;
      step_hist[hist_ptr] = step;
      hist_ptr            = (hist_ptr + 1) % RING_DEPTH;

      s.turn_count       = TURN_W'(turn_total);
      s.continuous_count = COUNT_W'(int'(reading) + turn_total * TURN_SPAN);
      s.angle_count      = COUNT_W'(int'(reading) - int'(bias_setting) + turn_total * TURN_SPAN);
      s.step_rate        = STEP_W'(step);
      // Integer division in SystemVerilog truncates toward zero, as the mean requires.
      s.mean_rate        = STEP_W'(step_total / RING_DEPTH);
      return s;
   endfunction

   // Driver. It offers the queued readings in bursts of random length separated by
   // random gaps, and holds a stalled transaction unchanged until it is taken. The
   // expectation for a reading is computed at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_samples.push_back(predict_sample(req_reading));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 && !steady_flow) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_readings.size() != 0) begin
               req_valid   <= 1'b1;
               req_reading <= pending_readings.pop_front();
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 24);
                  // Mostly short gaps, now and then none and now and then a long one.
                  case ($urandom_range(0, 7))
                     0, 1:    gap_left <= 0;
                     7:       gap_left <= $urandom_range(15, 40);
                     default: gap_left <= $urandom_range(1, 6);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. It stalls on a pattern drawn anew at random as its cycle counter runs, and once, early in
   // the random part, holds off for a long stretch while the driver keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 64 == 0) begin
            stall_mode <= stall_pattern_type'($urandom_range(0, 3));
         end
         if (random_phase && !hold_done && rsp_valid) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= (stall_cycle % 3 == 0);
            endcase
         end
      end
   end

   // Monitor. Every accepted response transaction is compared with the oldest expectation.
   always @(posedge clock) begin : monitor
      encoder_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("response with nothing expected (turn_count)", rsp_turn_count, 0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_turn_count !== want.turn_count)
               report_mismatch("turn_count", rsp_turn_count, want.turn_count);
            if (rsp_continuous_count !== want.continuous_count)
               report_mismatch("continuous_count", rsp_continuous_count, want.continuous_count);
            if (rsp_angle_count !== want.angle_count)
               report_mismatch("angle_count", rsp_angle_count, want.angle_count);
            if (rsp_step_rate !== want.step_rate)
               report_mismatch("step_rate", rsp_step_rate, want.step_rate);
            if (rsp_mean_rate !== want.mean_rate)
               report_mismatch("mean_rate", rsp_mean_rate, want.mean_rate);
         end
      end
   end

   // Waits until every queued reading has been taken and every response has arrived,
   // then lets the pipeline settle over a further drain period.
   task automatic wait_until_idle();
      while (pending_readings.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes one register over the csr port and mirrors it into the predictor.
   task automatic write_register(input eura_pkg::csr_index_type idx,
                                 input logic [READING_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == eura_pkg::CSR_ANGLE_BIAS) begin
         bias_setting = value;
      end else begin
         wrap_limit = value;
      end
   endtask

   // Queues whole turns of motion at the reset threshold. Forward turns climb in two
   // steps of about 4000 and fall back past the threshold; backward turns do the
   // opposite, so each group of three readings moves the turn count by one.
   task automatic queue_turns(input int count, input bit forward);
      int base;
      for (int k = 0; k < count; k++) begin
         base = $urandom_range(0, 191);
         pending_readings.push_back(READING_W'(base));
         if (forward) begin
            pending_readings.push_back(READING_W'(base + 4000));
            pending_readings.push_back(READING_W'(base + 8000));
         end else begin
            pending_readings.push_back(READING_W'(base + 8000));
            pending_readings.push_back(READING_W'(base + 4000));
         end
      end
   endtask

   // Queues plausible shaft motion: a position that moves with a velocity that changes
   // now and then, so that turn crossings occur naturally, mixed with some noise
   // readings and the odd standstill.
   task automatic queue_motion(input int count);
      int pos;
      int vel;
      int pick;
      pos = $urandom_range(0, 8191);
      vel = int'($urandom_range(0, 6000)) - 3000;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            pending_readings.push_back(READING_W'($urandom_range(0, 8191)));
         end else begin
            if (pick < 18) begin
               vel = int'($urandom_range(0, 6000)) - 3000;
            end else if (pick < 21) begin
               vel = int'($urandom_range(0, 16382)) - 8191;
            end else if (pick < 24) begin
               vel = 0;
            end
            pos = (((pos + vel) % TURN_SPAN) + TURN_SPAN) % TURN_SPAN;
            pending_readings.push_back(READING_W'(pos));
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      wait (!reset);
      @(posedge clock);

      // Reset configuration. The first reading is compared with a previous reading of
      // zero, so full scale counts as a backward crossing. Then steps exactly at and
      // just beyond the threshold in both directions, and a zero step.
      pending_readings = '{13'd8191, 13'd0, 13'd6500, 13'd0, 13'd6501, 13'd0,
                           13'd4096, 13'd4096, 13'd8191, 13'd1691};
      wait_until_idle();

      // A threshold of zero makes every non-zero step a crossing.
      write_register(eura_pkg::CSR_WRAP_THRESHOLD, 13'd0);
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd8191);
      pending_readings = '{13'd100, 13'd100, 13'd101, 13'd100, 13'd0, 13'd8191};
      wait_until_idle();

      // The largest threshold means no step can ever count as a crossing.
      write_register(eura_pkg::CSR_WRAP_THRESHOLD, 13'd8191);
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd4096);
      pending_readings = '{13'd0, 13'd8191, 13'd0, 13'd4095};
      wait_until_idle();

      // Whole turns at full rate with the reset threshold: forward crossings with no
      // bias, then backward crossings with the largest bias, which bring the turn
      // count back to where it started.
      steady_flow = 1'b1;
      write_register(eura_pkg::CSR_WRAP_THRESHOLD, eura_pkg::WRAP_THRESHOLD_RESET);
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd0);
      queue_turns(8, 1'b1);
      wait_until_idle();
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd8191);
      queue_turns(8, 1'b0);
      wait_until_idle();
      steady_flow = 1'b0;

      // Random motion under several settings, with idling on both sides.
      random_phase = 1'b1;
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd0);
      queue_motion(RANDOM_ITEMS);
      wait_until_idle();

      write_register(eura_pkg::CSR_WRAP_THRESHOLD, 13'd0);
      write_register(eura_pkg::CSR_ANGLE_BIAS, 13'd8191);
      queue_motion(RANDOM_ITEMS);
      wait_until_idle();

      write_register(eura_pkg::CSR_WRAP_THRESHOLD, 13'd8191);
      write_register(eura_pkg::CSR_ANGLE_BIAS, READING_W'($urandom_range(0, 8191)));
      queue_motion(RANDOM_ITEMS);
      wait_until_idle();

      write_register(eura_pkg::CSR_WRAP_THRESHOLD, READING_W'($urandom_range(0, 8191)));
      write_register(eura_pkg::CSR_ANGLE_BIAS, READING_W'($urandom_range(0, 8191)));
      queue_motion(RANDOM_ITEMS);
      wait_until_idle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/eura_pkg.sv
rtl/eura_cell.sv
rtl/eura_unwrap.sv
rtl/eura_mean.sv
rtl/encoder_unwrap_rate_average.sv
dv/encoder_unwrap_rate_average_tb.sv
